@@ rtl/core/pif_pkg.sv @@
`default_nettype none
package pif_pkg;

	localparam logic [2:0] MODE_SDEC = 3'd0;
	localparam logic [2:0] MODE_UDEC = 3'd1;
	localparam logic [2:0] MODE_OCT  = 3'd2;
	localparam logic [2:0] MODE_HEXL = 3'd3;
	localparam logic [2:0] MODE_HEXU = 3'd4;

	localparam logic [1:0] SIZE_SHORT = 2'd0;
	localparam logic [1:0] SIZE_INT   = 2'd1;
	localparam logic [1:0] SIZE_LONG  = 2'd2;

	localparam logic [7:0] CHAR_OPEN  = 8'h84;
	localparam logic [7:0] CHAR_CLOSE = 8'h83;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;

	localparam int RESULT_LIMIT = 40;
	localparam int DIGIT_MAX    = 22;

	// Emission phases
	localparam logic [3:0] PH_OPEN   = 4'd0;
	localparam logic [3:0] PH_LPAD   = 4'd1;
	localparam logic [3:0] PH_SIGN   = 4'd2;
	localparam logic [3:0] PH_PFX0   = 4'd3;
	localparam logic [3:0] PH_PFX1   = 4'd4;
	localparam logic [3:0] PH_ZPAD   = 4'd5;
	localparam logic [3:0] PH_PREC   = 4'd6;
	localparam logic [3:0] PH_OCT    = 4'd7;
	localparam logic [3:0] PH_DIGITS = 4'd8;
	localparam logic [3:0] PH_RPAD   = 4'd9;
	localparam logic [3:0] PH_CLOSE  = 4'd10;
	localparam logic [3:0] PH_DONE   = 4'd11;

	typedef struct packed {
		logic [2:0]  mode;
		logic [63:0] value_bits;
		logic [1:0]  size_class;
		logic        left_justify;
		logic        zero_pad;
		logic        show_sign;
		logic        space_sign;
		logic        alternate;
		logic [5:0]  field_width;
		logic [5:0]  precision;
		logic        has_precision;
	} pif_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} pif_result_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture item, prepare magnitude
		logic div_step;  // extract one octal/hex digit or one 16-bit chunk of a decimal digit
		logic plan;      // compute run lengths
		logic emit;      // advance the phase, producing at most one character
	} pif_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic emit_valid;  // current phase yields a character
		logic emit_last;
		logic emit_end;    // nothing more to emit
	} pif_stat_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10) c = CHAR_ZERO + {4'd0, d};
		else if (upper) c = 8'h41 + {4'd0, d} - 8'd10;
		else c = 8'h61 + {4'd0, d} - 8'd10;
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/pif_stream_if.sv @@
`default_nettype none
interface pif_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pif_ctrl.sv @@
`default_nettype none
module pif_ctrl
	import pif_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire pif_stat_t stat,
	output pif_cmd_t  cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PLAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       slot_free;

	// output register can take a character when empty or draining
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.div_step = (state_q == ST_DIV) && !stat.div_done;
		cmd.plan     = (state_q == ST_PLAN);
		cmd.emit     = (state_q == ST_EMIT) && slot_free && !stat.emit_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit && stat.emit_valid) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DIV;
				ST_DIV:  if (stat.div_done) state_q <= ST_PLAN;
				ST_PLAN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (stat.emit_end || (cmd.emit && stat.emit_valid && stat.emit_last))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/pif_datapath.sv @@
`default_nettype none
module pif_datapath
	import pif_pkg::*;
#(
	parameter int MAX_WIDTH     = 32,
	parameter int MAX_PRECISION = 32
) (
	input  wire logic       clk,
	input  wire pif_item_t  item,
	input  wire logic       codes,
	input  wire pif_cmd_t   cmd,
	output pif_stat_t       stat,
	output pif_result_t     result
);
	localparam int DW = $clog2(DIGIT_MAX + 1);
	localparam int RW = 8; // signed run counters, holds +-127

	logic [2:0]  mode_q;
	logic        left_q, alt_q, upper_q, plus_q, space_q, neg_q, zfill_q, hexpfx_q;
	logic        codes_q, valid_mode_q;
	logic [5:0]  width_in_q, prec_in_q;
	logic        hasp_q;
	logic [63:0] num_q;
	logic [3:0]  rem_q;     // running decimal remainder
	logic [1:0]  sub_q;     // 16-bit chunk index within a decimal digit
	logic [3:0]  digs_q [DIGIT_MAX];
	logic [DW-1:0] nd_q, di_q;
	logic signed [RW-1:0] pad_q, prec_q;
	logic        octz_q;
	logic [3:0]  phase_q;
	logic [5:0]  count_q;   // characters emitted
	logic [7:0]  char_q;
	logic        last_q;

	// sign extend / truncate
	logic [63:0] sx, mag;
	logic        neg;
	always_comb begin
		case (item.size_class)
			SIZE_SHORT: sx = {{48{item.value_bits[15]}}, item.value_bits[15:0]};
			SIZE_INT:   sx = {{32{item.value_bits[31]}}, item.value_bits[31:0]};
			default:    sx = item.value_bits;
		endcase
		neg = (item.mode == MODE_SDEC) && sx[63];
		if (item.mode == MODE_SDEC) mag = neg ? (64'd0 - sx) : sx;
		else begin
			case (item.size_class)
				SIZE_SHORT: mag = {48'd0, item.value_bits[15:0]};
				SIZE_INT:   mag = {32'd0, item.value_bits[31:0]};
				default:    mag = item.value_bits;
			endcase
		end
	end

	// octal and hex: one digit per step by shift and mask
	logic [63:0] quo;
	logic [3:0]  rem;
	logic        dec;
	always_comb begin
		dec = !(mode_q == MODE_OCT || mode_q == MODE_HEXL || mode_q == MODE_HEXU);
		if (mode_q == MODE_OCT) begin
			quo = num_q >> 3;
			rem = {1'b0, num_q[2:0]};
		end else begin
			quo = num_q >> 4;
			rem = num_q[3:0];
		end
	end

	// decimal: divide the top 16-bit chunk (with the carried remainder) by 10
	// through a reciprocal multiply, 2^23/10 rounded up; exact below 655360.
	// The quotient chunk is shifted in at the bottom, so four steps give
	// the whole quotient in num_q and one digit in the remainder.
	logic [19:0] dx;
	logic [43:0] dprod;
	logic [15:0] dq;
	logic [19:0] dqx10;
	logic [19:0] ddiff;
	logic [3:0]  dr;
	always_comb begin
		dx    = {rem_q, num_q[63:48]};
		dprod = {24'd0, dx} * 44'd838861;
		dq    = dprod[38:23];
		dqx10 = {1'b0, dq, 3'b000} + {3'b000, dq, 1'b0};
		ddiff = dx - dqx10;
		dr    = ddiff[3:0];
	end

	// planning arithmetic
	logic signed [RW-1:0] w0, p0, w1, p1;
	logic [5:0] wsat, psat;
	logic octz;
	always_comb begin
		wsat = (width_in_q > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width_in_q;
		psat = (prec_in_q > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : prec_in_q;
		if (!hasp_q) psat = 6'd1;
		w0 = RW'(wsat) - RW'(nd_q);
		p0 = RW'(psat) - RW'(nd_q);
		octz = alt_q && (mode_q == MODE_OCT) && (p0 <= 0);
		w1 = w0 - (octz ? RW'(1) : RW'(0));
		if (p0 > 0) begin
			w1 = w1 - p0;
			p1 = p0;
		end else p1 = '0;
		if (hexpfx_q) w1 = w1 - RW'(2);
		if (neg_q || plus_q || space_q) w1 = w1 - RW'(1);
	end

	// character for current phase
	logic       has_char;
	logic [7:0] ch;
	logic [3:0] nxt_phase;
	always_comb begin
		has_char  = 1'b0;
		ch        = CHAR_SPACE;
		nxt_phase = phase_q;
		case (phase_q)
			PH_OPEN: begin
				has_char = codes_q;
				ch = CHAR_OPEN;
				nxt_phase = PH_LPAD;
			end
			PH_LPAD: begin
				has_char = !zfill_q && !left_q && pad_q > 0;
				if (!has_char || pad_q <= 1) nxt_phase = PH_SIGN;
			end
			PH_SIGN: begin
				has_char = neg_q || plus_q || space_q;
				ch = neg_q ? CHAR_MINUS : (plus_q ? CHAR_PLUS : CHAR_SPACE);
				nxt_phase = PH_PFX0;
			end
			PH_PFX0: begin
				has_char = hexpfx_q;
				ch = CHAR_ZERO;
				nxt_phase = hexpfx_q ? PH_PFX1 : PH_ZPAD;
			end
			PH_PFX1: begin
				has_char = 1'b1;
				ch = upper_q ? 8'h58 : 8'h78;
				nxt_phase = PH_ZPAD;
			end
			PH_ZPAD: begin
				has_char = zfill_q && pad_q > 0;
				ch = CHAR_ZERO;
				if (!has_char || pad_q <= 1) nxt_phase = PH_PREC;
			end
			PH_PREC: begin
				has_char = prec_q > 0;
				ch = CHAR_ZERO;
				if (!has_char || prec_q <= 1) nxt_phase = PH_OCT;
			end
			PH_OCT: begin
				has_char = octz_q;
				ch = CHAR_ZERO;
				nxt_phase = PH_DIGITS;
			end
			PH_DIGITS: begin
				has_char = di_q != '0;
				ch = digit_char(digs_q[di_q - DW'(1)], upper_q);
				if (di_q <= DW'(1)) nxt_phase = PH_RPAD;
			end
			PH_RPAD: begin
				has_char = left_q && pad_q > 0;
				if (!has_char || pad_q <= 1) nxt_phase = PH_CLOSE;
			end
			PH_CLOSE: begin
				has_char = codes_q;
				ch = CHAR_CLOSE;
				nxt_phase = PH_DONE;
			end
			default: nxt_phase = PH_DONE;
		endcase
		if (!valid_mode_q && phase_q != PH_CLOSE && phase_q != PH_DONE) begin
			has_char = 1'b0;
			nxt_phase = PH_CLOSE;
		end
		if (count_q == 6'(RESULT_LIMIT)) begin
			has_char = 1'b0;
			nxt_phase = PH_DONE;
		end
	end

	// last: no later phase yields a character (cheap lookahead by phase)
	logic later;
	always_comb begin
		later = 1'b0;
		if (count_q == 6'(RESULT_LIMIT - 1)) later = 1'b0;
		else begin
			if (codes_q && phase_q < PH_CLOSE) later = 1'b1;
			if (valid_mode_q) begin
				if (phase_q == PH_RPAD && pad_q > 1 && left_q) later = 1'b1;
				if (phase_q < PH_RPAD && left_q && pad_q > 0) later = 1'b1;
				if (phase_q == PH_DIGITS && di_q > DW'(1)) later = 1'b1;
				if (phase_q < PH_DIGITS && nd_q != '0) later = 1'b1;
				if (phase_q < PH_OCT && octz_q) later = 1'b1;
				if (phase_q == PH_PREC && prec_q > 1) later = 1'b1;
				if (phase_q < PH_PREC && prec_q > 0) later = 1'b1;
				if (phase_q == PH_ZPAD && zfill_q && pad_q > 1) later = 1'b1;
				if (phase_q < PH_ZPAD && zfill_q && pad_q > 0) later = 1'b1;
				if (phase_q == PH_PFX0 && hexpfx_q) later = 1'b1;
				if (phase_q < PH_PFX0 && hexpfx_q) later = 1'b1;
				if (phase_q < PH_SIGN && (neg_q || plus_q || space_q)) later = 1'b1;
				if (phase_q == PH_LPAD && !zfill_q && !left_q && pad_q > 1) later = 1'b1;
			end
		end
	end

	// status and result outputs
	always_comb begin
		stat.div_done   = (sub_q == 2'd0) &&
			((num_q == 64'd0) || (nd_q == DW'(DIGIT_MAX)));
		stat.emit_valid = has_char;
		stat.emit_last  = !later;
		stat.emit_end   = (phase_q == PH_DONE);
		result.out_char = char_q;
		result.last     = last_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q       <= item.mode;
			valid_mode_q <= item.mode <= MODE_HEXU;
			left_q       <= item.left_justify;
			alt_q        <= item.alternate;
			upper_q      <= item.mode == MODE_HEXU;
			plus_q       <= item.mode == MODE_SDEC && item.show_sign;
			space_q      <= item.mode == MODE_SDEC && item.space_sign;
			neg_q        <= neg;
			zfill_q      <= item.zero_pad && !item.left_justify && !item.has_precision;
			hexpfx_q     <= item.alternate && (item.mode == MODE_HEXL ||
				item.mode == MODE_HEXU) && mag != 64'd0;
			width_in_q   <= item.field_width;
			prec_in_q    <= item.precision;
			hasp_q       <= item.has_precision;
			codes_q      <= codes;
			num_q        <= mag;
			rem_q        <= '0;
			sub_q        <= '0;
			nd_q         <= '0;
			phase_q      <= PH_OPEN;
			count_q      <= '0;
		end
		if (cmd.div_step) begin
			if (dec) begin
				num_q <= {num_q[47:0], dq};
				sub_q <= sub_q + 2'd1;
				if (sub_q == 2'd3) begin
					digs_q[nd_q] <= dr;
					nd_q         <= nd_q + DW'(1);
					rem_q        <= '0;
				end else rem_q <= dr;
			end else begin
				digs_q[nd_q] <= rem;
				num_q        <= quo;
				nd_q         <= nd_q + DW'(1);
			end
		end
		if (cmd.plan) begin
			pad_q  <= w1;
			prec_q <= p1;
			octz_q <= octz;
			di_q   <= nd_q;
		end
		if (cmd.emit) begin
			phase_q <= nxt_phase;
			if (has_char) begin
				char_q  <= ch;
				last_q  <= !later;
				count_q <= count_q + 6'd1;
				if ((phase_q == PH_LPAD || phase_q == PH_ZPAD || phase_q == PH_RPAD))
					pad_q <= pad_q - RW'(1);
				if (phase_q == PH_PREC) prec_q <= prec_q - RW'(1);
				if (phase_q == PH_DIGITS) di_q <= di_q - DW'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/printf_integer_formatter.sv @@
// printf integer formatter.
// Input channel in: one transfer per conversion (mode, value, size class,
// flags, width, precision). Output channel out: one transfer per character,
// last set on the final character of the conversion.
// Config: cfg_we/cfg_data write the spacing-codes enable (0x84 before and
// 0x83 after each conversion); write only while idle.
// Per item: a load step, then digit extraction: one digit per step for
// octal (up to 22) and hex (up to 16), four steps per digit for decimal
// (up to 20 digits), then a plan step, then one emit step per character
// or empty phase, at most 40 characters. A new item is taken in the cycle
// after the last character has entered the output register.
// Decimal digits: the 64-bit value is divided by 10 one 16-bit chunk per
// cycle through a reciprocal multiply.
// Reset (arst_n low) clears the spacing enable and the controller; no
// output is pending afterwards. When the receiver stalls, the output
// register holds its character and emission pauses; nothing is dropped.
// A conversion that prints nothing produces no transfer at all.
`default_nettype none
module printf_integer_formatter
	import pif_pkg::*;
#(
	parameter int MAX_WIDTH     = 32,
	parameter int MAX_PRECISION = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_data,
	pif_stream_if.sink   in,
	pif_stream_if.source out
);
	logic      codes_q;
	pif_cmd_t  cmd;
	pif_stat_t stat;
	pif_result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) codes_q <= 1'b0;
		else if (cfg_we) codes_q <= cfg_data;
	end

	pif_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.stat(stat), .cmd(cmd)
	);

	pif_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_PRECISION(MAX_PRECISION)) u_dp (
		.clk(clk), .item(in.payload), .codes(codes_q),
		.cmd(cmd), .stat(stat), .result(res)
	);

	assign out.payload = res;
endmodule
`default_nettype wire
